@@ hdl/dmpi_pkg.sv @@
// Shared types and constants for the dual motor PI speed controller.
`timescale 1ns / 1ps

package dmpi_pkg;

    localparam int ACC_W  = 16;
    localparam int STEP_W = 5;
    localparam int IDX_W  = 3;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam int RIGHT_IDX = 0;
    localparam int LEFT_IDX  = 1;

    localparam logic [IDX_W-1:0] REG_SPEED_REF  = 3'd0;
    localparam logic [IDX_W-1:0] REG_COUNT_SCL  = 3'd1;
    localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 3'd3;
    localparam logic [IDX_W-1:0] REG_DUTY_LIMIT = 3'd4;

    localparam logic [7:0]  RST_SPEED_REF  = 8'd11;
    localparam logic [7:0]  RST_COUNT_SCL  = 8'd2;
    localparam logic [15:0] RST_PROP_GAIN  = 16'd10;
    localparam logic [15:0] RST_INTEG_GAIN = 16'd2;
    localparam logic [7:0]  RST_DUTY_LIMIT = 8'hAA;

    localparam logic [STEP_W-1:0] STEPS_8  = 5'd8;
    localparam logic [STEP_W-1:0] STEPS_16 = 5'd16;

    typedef struct packed {
        logic              acc_clear;
        logic [ACC_W-1:0]  multiplicand;
        logic [ACC_W-1:0]  multiplier;
        logic [STEP_W-1:0] steps;
    } mac_cmd_t;

endpackage

@@ hdl/dual_motor_pi_speed_control_top.sv @@
// Top level of the dual motor PI speed controller: config registers, sequencer, output stage.
`timescale 1ns / 1ps

// An encoder sample transaction (opcode 0) completes as it is accepted. A control tick
// transaction (opcode 1) runs until its duty pair is presented: both channels go
// through one shared bit-serial multiply-accumulate unit that retires one multiplier bit
// per cycle, 8 steps for count times scale, 16 for the proportional product and 8 for the
// integral product, for each channel in turn, right then left. No input is taken while
// a tick is in progress. The finished duty pair sits in an output register, so samples
// are accepted while it waits to be taken. Configuration writes are always ready.

module dual_motor_pi_speed_control_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic [1:0]                  encoder_bits,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  duty_right,
    output logic [7:0]                  duty_left,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dmpi_pkg::IDX_W-1:0]  cfg_index,
    input  logic [15:0]                 cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAS,
        ST_PROP,
        ST_INTEG,
        ST_DONE
    } state_t;

    localparam logic CH_RIGHT = 1'b0;
    localparam logic CH_LEFT  = 1'b1;

    state_t             state_reg, state_next;
    logic               ch_reg, ch_next;
    logic [7:0]         cnt_l_reg, cnt_l_next;
    logic [7:0]         err_r_reg, err_r_next;
    logic [7:0]         err_l_reg, err_l_next;
    logic [7:0]         hold_r_reg, hold_r_next;
    logic               mac_start_reg, mac_start_next;
    dmpi_pkg::mac_cmd_t mac_cmd_reg, mac_cmd_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         duty_r_reg, duty_r_next;
    logic [7:0]         duty_l_reg, duty_l_next;

    logic [7:0]  speed_ref_reg;
    logic [7:0]  count_scl_reg;
    logic [15:0] prop_gain_reg;
    logic [15:0] integ_gain_reg;
    logic [7:0]  duty_limit_reg;

    logic                        in_accept;
    logic                        tick_accept;
    logic                        mac_busy;
    logic [dmpi_pkg::ACC_W-1:0]  mac_acc;
    logic                        mac_idle;
    logic [7:0]                  count_right;
    logic [7:0]                  count_left;
    logic [7:0]                  err_cur;
    logic [15:0]                 ref_wide;
    logic [15:0]                 diff;
    logic [7:0]                  err_new;
    logic [7:0]                  duty_clamped;

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_accept   = in_valid && in_ready;
    assign tick_accept = in_accept && (opcode == dmpi_pkg::OP_TICK);
    assign cfg_ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_ref_reg  <= dmpi_pkg::RST_SPEED_REF;
            count_scl_reg  <= dmpi_pkg::RST_COUNT_SCL;
            prop_gain_reg  <= dmpi_pkg::RST_PROP_GAIN;
            integ_gain_reg <= dmpi_pkg::RST_INTEG_GAIN;
            duty_limit_reg <= dmpi_pkg::RST_DUTY_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dmpi_pkg::REG_SPEED_REF:  speed_ref_reg  <= cfg_data[7:0];
                dmpi_pkg::REG_COUNT_SCL:  count_scl_reg  <= cfg_data[7:0];
                dmpi_pkg::REG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                dmpi_pkg::REG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                dmpi_pkg::REG_DUTY_LIMIT: duty_limit_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    dmpi_edge u_edge (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_en   (in_accept && (opcode == dmpi_pkg::OP_SAMPLE)),
        .levels      (encoder_bits),
        .clear       (tick_accept),
        .count_right (count_right),
        .count_left  (count_left)
    );

    dmpi_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_start_reg),
        .cmd   (mac_cmd_reg),
        .busy  (mac_busy),
        .acc   (mac_acc)
    );

    assign mac_idle     = !mac_start_reg && !mac_busy;
    assign err_cur      = (ch_reg == CH_LEFT) ? err_l_reg : err_r_reg;
    assign ref_wide     = {8'd0, speed_ref_reg};
    assign diff         = (mac_acc > ref_wide) ? (mac_acc - ref_wide) : (ref_wide - mac_acc);
    assign err_new      = err_cur + speed_ref_reg - mac_acc[7:0];
    assign duty_clamped = (mac_acc > {8'd0, duty_limit_reg}) ? duty_limit_reg : mac_acc[7:0];

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        cnt_l_next     = cnt_l_reg;
        err_r_next     = err_r_reg;
        err_l_next     = err_l_reg;
        hold_r_next    = hold_r_reg;
        mac_start_next = 1'b0;
        mac_cmd_next   = mac_cmd_reg;
        out_valid_next = out_valid_reg;
        duty_r_next    = duty_r_reg;
        duty_l_next    = duty_l_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (tick_accept)
                begin
                    cnt_l_next                = count_left;
                    ch_next                   = CH_RIGHT;
                    mac_start_next            = 1'b1;
                    mac_cmd_next.acc_clear    = 1'b1;
                    mac_cmd_next.multiplicand = {8'd0, count_scl_reg};
                    mac_cmd_next.multiplier   = {8'd0, count_right};
                    mac_cmd_next.steps        = dmpi_pkg::STEPS_8;
                    state_next                = ST_MEAS;
                end
            end
            ST_MEAS:
            begin
                if (mac_idle)
                begin
                    if (ch_reg == CH_LEFT)
                    begin
                        err_l_next = err_new;
                    end
                    else
                    begin
                        err_r_next = err_new;
                    end
                    mac_start_next            = 1'b1;
                    mac_cmd_next.acc_clear    = 1'b1;
                    mac_cmd_next.multiplicand = prop_gain_reg;
                    mac_cmd_next.multiplier   = diff;
                    mac_cmd_next.steps        = dmpi_pkg::STEPS_16;
                    state_next                = ST_PROP;
                end
            end
            ST_PROP:
            begin
                if (mac_idle)
                begin
                    mac_start_next            = 1'b1;
                    mac_cmd_next.acc_clear    = 1'b0;
                    mac_cmd_next.multiplicand = integ_gain_reg;
                    mac_cmd_next.multiplier   = {8'd0, err_cur};
                    mac_cmd_next.steps        = dmpi_pkg::STEPS_8;
                    state_next                = ST_INTEG;
                end
            end
            ST_INTEG:
            begin
                if (mac_idle)
                begin
                    if (ch_reg == CH_RIGHT)
                    begin
                        hold_r_next               = duty_clamped;
                        ch_next                   = CH_LEFT;
                        mac_start_next            = 1'b1;
                        mac_cmd_next.acc_clear    = 1'b1;
                        mac_cmd_next.multiplicand = {8'd0, count_scl_reg};
                        mac_cmd_next.multiplier   = {8'd0, cnt_l_reg};
                        mac_cmd_next.steps        = dmpi_pkg::STEPS_8;
                        state_next                = ST_MEAS;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    duty_r_next    = hold_r_reg;
                    duty_l_next    = duty_clamped;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= CH_RIGHT;
            cnt_l_reg     <= 8'd0;
            err_r_reg     <= 8'd0;
            err_l_reg     <= 8'd0;
            hold_r_reg    <= 8'd0;
            mac_start_reg <= 1'b0;
            mac_cmd_reg   <= '0;
            out_valid_reg <= 1'b0;
            duty_r_reg    <= 8'd0;
            duty_l_reg    <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            cnt_l_reg     <= cnt_l_next;
            err_r_reg     <= err_r_next;
            err_l_reg     <= err_l_next;
            hold_r_reg    <= hold_r_next;
            mac_start_reg <= mac_start_next;
            mac_cmd_reg   <= mac_cmd_next;
            out_valid_reg <= out_valid_next;
            duty_r_reg    <= duty_r_next;
            duty_l_reg    <= duty_l_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign duty_right = duty_r_reg;
    assign duty_left  = duty_l_reg;

    a_start_makes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mac_start_reg |=> mac_busy)
        else $error("multiply unit not busy after start");

    a_ready_only_when_mac_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!mac_busy && !mac_start_reg))
        else $error("input ready while multiply unit active");

    a_tick_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> !in_ready)
        else $error("input ready right after control tick");

    a_busy_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
        mac_busy |-> (state_reg != ST_IDLE && state_reg != ST_DONE))
        else $error("multiply unit busy outside compute states");

endmodule

@@ hdl/dmpi_edge.sv @@
// Encoder level tracker and per-channel rising edge counters.
`timescale 1ns / 1ps

module dmpi_edge (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_en,
    input  logic [1:0] levels,
    input  logic       clear,
    output logic [7:0] count_right,
    output logic [7:0] count_left
);

    logic [1:0] prev_reg, prev_next;
    logic       primed_reg, primed_next;
    logic [7:0] cnt_r_reg, cnt_r_next;
    logic [7:0] cnt_l_reg, cnt_l_next;

    always_comb
    begin
        prev_next   = prev_reg;
        primed_next = primed_reg;
        cnt_r_next  = cnt_r_reg;
        cnt_l_next  = cnt_l_reg;
        if (clear)
        begin
            cnt_r_next = 8'd0;
            cnt_l_next = 8'd0;
        end
        else if (sample_en)
        begin
            if (primed_reg && !prev_reg[dmpi_pkg::RIGHT_IDX] && levels[dmpi_pkg::RIGHT_IDX])
            begin
                cnt_r_next = cnt_r_reg + 8'd1;
            end
            if (primed_reg && !prev_reg[dmpi_pkg::LEFT_IDX] && levels[dmpi_pkg::LEFT_IDX])
            begin
                cnt_l_next = cnt_l_reg + 8'd1;
            end
            prev_next   = levels;
            primed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= 2'd0;
            primed_reg <= 1'b0;
            cnt_r_reg  <= 8'd0;
            cnt_l_reg  <= 8'd0;
        end
        else
        begin
            prev_reg   <= prev_next;
            primed_reg <= primed_next;
            cnt_r_reg  <= cnt_r_next;
            cnt_l_reg  <= cnt_l_next;
        end
    end

    assign count_right = cnt_r_reg;
    assign count_left  = cnt_l_reg;

endmodule

@@ hdl/dmpi_mac.sv @@
// Bit-serial multiply-accumulate unit, one multiplier bit per cycle, modulo 2^16.
`timescale 1ns / 1ps

module dmpi_mac (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  dmpi_pkg::mac_cmd_t           cmd,
    output logic                         busy,
    output logic [dmpi_pkg::ACC_W-1:0]   acc
);

    logic [dmpi_pkg::ACC_W-1:0]  mcand_reg, mcand_next;
    logic [dmpi_pkg::ACC_W-1:0]  mplr_reg, mplr_next;
    logic [dmpi_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [dmpi_pkg::STEP_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        if (start)
        begin
            mcand_next = cmd.multiplicand;
            mplr_next  = cmd.multiplier;
            cnt_next   = cmd.steps;
            if (cmd.acc_clear)
            begin
                acc_next = '0;
            end
        end
        else if (cnt_reg != '0)
        begin
            if (mplr_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next = {mcand_reg[dmpi_pkg::ACC_W-2:0], 1'b0};
            mplr_next  = {1'b0, mplr_reg[dmpi_pkg::ACC_W-1:1]};
            cnt_next   = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        mplr_reg  <= mplr_next;
        acc_reg   <= acc_next;
    end

    assign busy = (cnt_reg != '0);
    assign acc  = acc_reg;

endmodule
